// ----- rtl/ansi_pkg.sv -----
// ----------------------------------------------------------------------------
// ANSI escape stripper package
// Byte codes, parser modes and beat types shared by the stripper's files.
// ----------------------------------------------------------------------------
package ansi_pkg;

   localparam logic [7:0]  CH_ESC         = 8'h1B;
   localparam logic [7:0]  CH_BEL         = 8'h07;
   localparam logic [7:0]  CH_CR          = 8'h0D;
   localparam logic [7:0]  CH_LBRACKET    = 8'h5B;
   localparam logic [7:0]  CH_RBRACKET    = 8'h5D;
   localparam logic [7:0]  FINAL_LO       = 8'h40;
   localparam logic [7:0]  FINAL_HI       = 8'h7E;
   localparam logic [15:0] CAPACITY_RESET = 16'd4096;

   typedef enum logic [2:0] {
      MODE_TEXT,
      MODE_ESC,
      MODE_CSI,
      MODE_OSC,
      MODE_OSC_ESC
   } parse_mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic        byte_valid;
      logic [7:0]  out_byte;
      logic        end_of_text;
      logic [15:0] total_count;
   } rsp_item_type;

endpackage

// ----- rtl/ansi_if.sv -----
// ----------------------------------------------------------------------------
// ANSI stripper channels
// Valid/ready channels for raw input bytes and for filtered result beats.
// ----------------------------------------------------------------------------
interface ansi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last;

   modport source (output valid, output data_byte, output has_byte, output last,
                   input ready);
   modport sink   (input valid, input data_byte, input has_byte, input last,
                   output ready);
endinterface

interface ansi_rsp_if;
   logic        valid;
   logic        ready;
   logic        byte_valid;
   logic [7:0]  out_byte;
   logic        end_of_text;
   logic [15:0] total_count;

   modport source (output valid, output byte_valid, output out_byte,
                   output end_of_text, output total_count, input ready);
   modport sink   (input valid, input byte_valid, input out_byte,
                   input end_of_text, input total_count, output ready);
endinterface

// ----- rtl/ansi_parser.sv -----
// ----------------------------------------------------------------------------
// ANSI parser step
// Next parser mode, next emitted count and the result beat for one byte.
// ----------------------------------------------------------------------------
module ansi_parser
   import ansi_pkg::*;
(
   input  parse_mode_type mode_cur,
   input  logic [15:0]    count_cur,
   input  logic [15:0]    capacity,
   input  req_item_type   item,
   output parse_mode_type mode_next,
   output logic [15:0]    count_next,
   output rsp_item_type   result,
   output logic           result_valid
);

   logic [15:0] limit;
   logic        emit;

   // limit saturates at zero for a zero capacity
   assign limit = (capacity == 16'd0) ? 16'd0 : capacity - 16'd1;

   assign emit = item.has_byte && (mode_cur == MODE_TEXT) &&
                 (item.data_byte != CH_ESC) && (item.data_byte != CH_CR) &&
                 (count_cur < limit);

   // next state
   always_comb begin
      mode_next = mode_cur;
      if (item.has_byte) begin
         case (mode_cur)
            MODE_TEXT: begin
               if (item.data_byte == CH_ESC) mode_next = MODE_ESC;
            end
            MODE_ESC: begin
               if (item.data_byte == CH_LBRACKET)      mode_next = MODE_CSI;
               else if (item.data_byte == CH_RBRACKET) mode_next = MODE_OSC;
               else                                    mode_next = MODE_TEXT;
            end
            MODE_CSI: begin
               if (item.data_byte inside {[FINAL_LO:FINAL_HI]}) mode_next = MODE_TEXT;
            end
            MODE_OSC: begin
               if (item.data_byte == CH_BEL)      mode_next = MODE_TEXT;
               else if (item.data_byte == CH_ESC) mode_next = MODE_OSC_ESC;
            end
            default: begin
               mode_next = MODE_TEXT;
            end
         endcase
      end
      if (item.last) mode_next = MODE_TEXT;
   end

   // outputs
   always_comb begin
      result.byte_valid  = emit;
      result.out_byte    = emit ? item.data_byte : 8'd0;
      result.end_of_text = item.last;
      result.total_count = emit ? count_cur + 16'd1 : count_cur;
      result_valid       = emit || item.last;
      count_next         = item.last ? 16'd0 : result.total_count;
   end

endmodule

// ----- rtl/ansi_escape_stripper.sv -----
// ----------------------------------------------------------------------------
// ANSI escape stripper
// Filters bytes to plain text; drops CR, escape sequences and overflow bytes.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  --------+-----+-------------+-----------------------------------------------
//  req     | in  | valid/ready | data_byte[7:0], has_byte, last
//  rsp     | out | valid/ready | byte_valid, out_byte[7:0], end_of_text,
//          |     |             | total_count[15:0]
//  csr     | in  | write_en    | capacity[15:0]
//
//  One byte per cycle while rsp is not stalled; an input beat passes
//  through the input register, then the result register, before rsp
//  valid rises for its result.
//  The parser mode and emitted count update as a beat leaves the input
//  register, so consecutive bytes chain through one pass of parser logic.
//  Reset clears the mode, the count, both valid flags and sets capacity
//  to 4096.
//  A stalled rsp holds its beat and the input beat behind it, whether that
//  beat makes a result or not; req drops ready once the input register fills.
// ----------------------------------------------------------------------------
module ansi_escape_stripper
   import ansi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   ansi_req_if.sink     req_chan,
   ansi_rsp_if.source   rsp_chan,
   input  logic         csr_write_enable,
   input  logic [15:0]  csr_write_data
);

   // input register
   logic           in_valid_ff, in_valid_in;
   req_item_type   in_item_ff;

   // parser state
   parse_mode_type mode_ff, mode_in;
   logic [15:0]    count_ff, count_in;
   logic [15:0]    capacity_ff;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_item_type   rsp_item_ff;

   // parser outputs
   rsp_item_type   step_result;
   logic           step_result_valid;

   logic           req_accept;
   logic           rsp_accept;
   logic           advance;

   // Advance the input beat when the result register is free or being taken;
   // a beat without a result advances on the same terms.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_accept = req_chan.valid && req_chan.ready;
   assign rsp_accept = rsp_valid_ff && rsp_chan.ready;

   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_accept;
      if (advance && step_result_valid) rsp_valid_in = 1'b1;
   end

   ansi_parser u_parser (
      .mode_cur     (mode_ff),
      .count_cur    (count_ff),
      .capacity     (capacity_ff),
      .item         (in_item_ff),
      .mode_next    (mode_in),
      .count_next   (count_in),
      .result       (step_result),
      .result_valid (step_result_valid)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_TEXT;
         count_ff     <= 16'd0;
         capacity_ff  <= CAPACITY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
         end
         if (csr_write_enable) capacity_ff <= csr_write_data;
      end
   end

   // payload: hold until the next beat lands
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.data_byte <= req_chan.data_byte;
         in_item_ff.has_byte  <= req_chan.has_byte;
         in_item_ff.last      <= req_chan.last;
      end
      if (advance && step_result_valid) rsp_item_ff <= step_result;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.byte_valid  = rsp_item_ff.byte_valid;
   assign rsp_chan.out_byte    = rsp_item_ff.out_byte;
   assign rsp_chan.end_of_text = rsp_item_ff.end_of_text;
   assign rsp_chan.total_count = rsp_item_ff.total_count;

   // a closing beat leaves the parser at the start of a fresh text
   a_close_resets: assert property (@(posedge clock) disable iff (reset)
      advance && in_item_ff.last |=> mode_ff == MODE_TEXT && count_ff == 16'd0)
      else $error("close did not reset parser state");

   // the emitted count grows by at most one per beat
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      advance && !in_item_ff.last |=>
         count_ff == $past(count_ff) || count_ff == $past(count_ff) + 16'd1)
      else $error("emitted count jumped");

   // every result beat carries a byte or closes the text
   a_rsp_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_item_ff.byte_valid || rsp_item_ff.end_of_text)
      else $error("empty result beat");

   // an emitted byte is always counted
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.byte_valid |-> rsp_item_ff.total_count != 16'd0)
      else $error("emitted byte with zero count");

endmodule

// ----- dv/tb_ansi_escape_stripper.sv -----
// ----------------------------------------------------------------------------
// ANSI escape stripper testbench
// Drives raw bytes through the stripper under random source and sink gaps.
// A local model of the parser and the emitted-byte count predicts each
// result beat not typed in by hand. The run steps through several buffer
// capacities, from zero to full scale.
// ----------------------------------------------------------------------------
module tb_ansi_escape_stripper;
   import ansi_pkg::*;

   localparam int unsigned     GAP_MAX         = 18;
   localparam int unsigned     HOLD_CYCLES     = 200;
   localparam int unsigned     DRAIN_CYCLES    = 8;
   localparam int unsigned     ITEMS_PER_PHASE = 165;
   localparam int unsigned     PHASE_COUNT     = 8;
   localparam longint unsigned CYCLE_LIMIT     = 300000;
   localparam rsp_item_type    NO_RSP          = '0;

   // One directed row: the input beat, and the result typed in by hand
   // where it is obvious (otherwise the local model decides).
   typedef struct {
      req_item_type beat;
      bit           typed;
      rsp_item_type typed_rsp;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;

   ansi_req_if req_bus ();
   ansi_rsp_if rsp_bus ();

   ansi_escape_stripper uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Local copy of the stripper state and its one register.
   parse_mode_type filter_mode      = MODE_TEXT;
   logic [15:0]    text_count       = '0;
   logic [15:0]    capacity_setting = CAPACITY_RESET;

   rsp_item_type expected_beats [$];
   req_item_type pending_beats [$];
   rsp_item_type oldest_expected;

   int unsigned     sender_gap_max   = GAP_MAX;
   int unsigned     receiver_gap_max = GAP_MAX;
   bit              rsp_hold_request = 1'b0;
   longint unsigned cycle_count      = 0;

   int unsigned mismatch_count   = 0;
   int unsigned beats_sent       = 0;
   int unsigned stimulus_items   = 0;
   int unsigned results_checked  = 0;
   int unsigned texts_closed     = 0;
   int unsigned bytes_emitted    = 0;
   int unsigned dropped_full     = 0;
   int unsigned capacity_writes  = 0;
   int unsigned held_off_cycles  = 0;

   // Directed opening: field extremes, a close on an empty text, carriage
   // return, a two-byte escape, CSI with the lowest final byte, OSC closed
   // by BEL and by ESC plus a byte, an idle beat, and an escape left open
   // at close that must not leak into the next text.
   directed_row_type directed_rows [0:24] = '{
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{1'b0, 8'h00, 1'b1, 16'd0}},
      '{'{8'h41, 1'b1, 1'b0}, 1'b1, '{1'b1, 8'h41, 1'b0, 16'd1}},
      '{'{8'h00, 1'b1, 1'b0}, 1'b1, '{1'b1, 8'h00, 1'b0, 16'd2}},
      '{'{8'hFF, 1'b1, 1'b0}, 1'b1, '{1'b1, 8'hFF, 1'b0, 16'd3}},
      '{'{CH_CR, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_ESC, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h78, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_ESC, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_LBRACKET, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h3F, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{FINAL_LO, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_ESC, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_RBRACKET, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h78, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_BEL, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_ESC, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_RBRACKET, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_ESC, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h6B, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h5A, 1'b1, 1'b0}, 1'b1, '{1'b1, 8'h5A, 1'b0, 16'd4}},
      '{'{8'hA5, 1'b0, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_ESC, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_LBRACKET, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{1'b0, 8'h00, 1'b1, 16'd4}},
      '{'{8'h71, 1'b1, 1'b1}, 1'b1, '{1'b1, 8'h71, 1'b1, 16'd1}}
   };

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Advance the stripper model by one accepted beat; return 1 when the
   // beat yields a result, which is then placed in result.
   function automatic bit strip_step(input req_item_type beat, output rsp_item_type result);
      bit          emitted;
      logic [16:0] limit;
      emitted = 1'b0;
      // An empty buffer saturates the limit at zero rather than wrapping.
      limit = (capacity_setting != 16'd0) ? {1'b0, capacity_setting} - 17'd1 : 17'd0;
      if (beat.has_byte) begin
         case (filter_mode)
            MODE_TEXT: begin
               if (beat.data_byte == CH_ESC) begin
                  filter_mode = MODE_ESC;
               end else if (beat.data_byte != CH_CR) begin
                  if ({1'b0, text_count} < limit) begin
                     text_count = text_count + 16'd1;
                     emitted = 1'b1;
                  end else begin
                     dropped_full++;
                  end
               end
            end
            MODE_ESC: begin
               if (beat.data_byte == CH_LBRACKET) filter_mode = MODE_CSI;
               else if (beat.data_byte == CH_RBRACKET) filter_mode = MODE_OSC;
               else filter_mode = MODE_TEXT;
            end
            MODE_CSI: begin
               if (beat.data_byte >= FINAL_LO && beat.data_byte <= FINAL_HI)
                  filter_mode = MODE_TEXT;
            end
            MODE_OSC: begin
               if (beat.data_byte == CH_BEL) filter_mode = MODE_TEXT;
               else if (beat.data_byte == CH_ESC) filter_mode = MODE_OSC_ESC;
            end
            default: begin
               filter_mode = MODE_TEXT;
            end
         endcase
      end
      result.byte_valid  = emitted;
      result.out_byte    = emitted ? beat.data_byte : 8'h00;
      result.end_of_text = beat.last;
      result.total_count = text_count;
      // A close drops any unfinished sequence and restarts the count.
      if (beat.last) begin
         filter_mode = MODE_TEXT;
         text_count  = '0;
      end
      return emitted || beat.last;
   endfunction

   function automatic void add_beat(input logic [7:0] value, input bit has, input bit closes);
      req_item_type beat;
      beat.data_byte = value;
      beat.has_byte  = has;
      beat.last      = closes;
      pending_beats.push_back(beat);
      // Idle beats are ignored by the block and do not count as stimulus.
      if (has || closes) stimulus_items++;
   endfunction

   // Queue one random chunk of a terminal stream: mostly plain text or
   // well-formed sequences, else bare escapes, CRs, closes, idles or noise.
   function automatic void queue_segment();
      int unsigned pick;
      int unsigned n;
      logic [7:0]  b;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         n = $urandom_range(1, 8);
         repeat (n) begin
            if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(8'h80, 8'hFF));
            else b = 8'($urandom_range(8'h20, 8'h7E));
            add_beat(b, 1'b1, $urandom_range(0, 29) == 0);
         end
      end else if (pick < 55) begin
         // CSI: parameter and intermediate bytes, then a final byte
         add_beat(CH_ESC, 1'b1, 1'b0);
         add_beat(CH_LBRACKET, 1'b1, 1'b0);
         n = $urandom_range(0, 4);
         repeat (n) add_beat(8'($urandom_range(8'h20, 8'h3F)), 1'b1, 1'b0);
         add_beat(8'($urandom_range(FINAL_LO, FINAL_HI)), 1'b1, 1'b0);
      end else if (pick < 65) begin
         // OSC: payload free of BEL and ESC, then either terminator
         add_beat(CH_ESC, 1'b1, 1'b0);
         add_beat(CH_RBRACKET, 1'b1, 1'b0);
         n = $urandom_range(0, 6);
         repeat (n) add_beat(8'($urandom_range(8'h20, 8'hFF)), 1'b1, 1'b0);
         if ($urandom_range(0, 1) == 0) begin
            add_beat(CH_BEL, 1'b1, 1'b0);
         end else begin
            add_beat(CH_ESC, 1'b1, 1'b0);
            add_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
         end
      end else if (pick < 72) begin
         add_beat(CH_ESC, 1'b1, 1'b0);
         add_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end else if (pick < 80) begin
         add_beat(CH_CR, 1'b1, 1'b0);
      end else if (pick < 88) begin
         add_beat(8'($urandom_range(0, 255)), $urandom_range(0, 1) == 1, 1'b1);
      end else if (pick < 91) begin
         add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end else begin
         n = $urandom_range(1, 4);
         repeat (n)
            add_beat(8'($urandom_range(0, 255)), 1'b1, $urandom_range(0, 15) == 0);
      end
   endfunction

   // Offer one beat after a random gap and hold it until it is taken;
   // valid stays high into the next beat when that one has no gap.
   task automatic send_beat(input req_item_type beat, input bit typed,
                            input rsp_item_type typed_rsp);
      int unsigned  gap;
      rsp_item_type predicted;
      bit           produces;
      gap = $urandom_range(0, sender_gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= beat.data_byte;
      req_bus.has_byte  <= beat.has_byte;
      req_bus.last      <= beat.last;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
      produces = strip_step(beat, predicted);
      if (typed) expected_beats.push_back(typed_rsp);
      else if (produces) expected_beats.push_back(predicted);
   endtask

   // Drop valid and wait for every result, then let beats that make no
   // result leave the pipeline before anything else happens.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      capacity_setting = value;
      capacity_writes++;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Sink side: draw a stall per beat, or hold off for a long stretch when
   // asked, so the stripper fills up and stops taking input.
   initial begin
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      forever begin
         if (rsp_hold_request) begin
            stall = HOLD_CYCLES;
            rsp_hold_request = 1'b0;
            held_off_cycles += HOLD_CYCLES;
         end else begin
            stall = $urandom_range(0, receiver_gap_max);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid && !rsp_hold_request);
      end
   end

   // Compare every result beat taken against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_checked++;
         if (rsp_bus.end_of_text) texts_closed++;
         if (rsp_bus.byte_valid) bytes_emitted++;
         if (expected_beats.size() == 0) begin
            $display("%0t: result beat with none expected, expected nothing, actual %0b/0x%0h/%0b/%0d",
                     $time, rsp_bus.byte_valid, rsp_bus.out_byte, rsp_bus.end_of_text,
                     rsp_bus.total_count);
            mismatch_count++;
         end else begin
            oldest_expected = expected_beats.pop_front();
            check_field("byte_valid", 32'(oldest_expected.byte_valid),
                        32'(rsp_bus.byte_valid));
            check_field("out_byte", 32'(oldest_expected.out_byte), 32'(rsp_bus.out_byte));
            check_field("end_of_text", 32'(oldest_expected.end_of_text),
                        32'(rsp_bus.end_of_text));
            check_field("total_count", 32'(oldest_expected.total_count),
                        32'(rsp_bus.total_count));
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached with %0d results outstanding",
                  $time, expected_beats.size());
         $display("[ansi_escape_stripper] ERROR");
         $finish;
      end
   end

   initial begin
      int unsigned phase;
      int unsigned target;
      bit          quiet;
      logic [15:0] capacity_plan [0:PHASE_COUNT-1];
      reset             <= 1'b1;
      csr_write_enable  <= 1'b0;
      csr_write_data    <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.has_byte  <= 1'b0;
      req_bus.last      <= 1'b0;

      // Capacities: a moderate one, then lowered mid-text, empty, the
      // largest that still emits nothing, full scale, small, random, and
      // back to the reset value. Texts run on across the writes.
      capacity_plan = '{16'd40, 16'd2, 16'd0, 16'd1, 16'hFFFF, 16'd6, 16'd0,
                        CAPACITY_RESET};
      capacity_plan[6] = 16'($urandom_range(3, 300));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table at the reset capacity.
      foreach (directed_rows[i])
         send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].typed_rsp);
      drain_results();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         // Two phases run back to back with no gaps; the first also opens
         // with a long sink hold-off while the source keeps pushing.
         quiet = (phase == 0 || phase == 5);
         sender_gap_max   = quiet ? 0 : GAP_MAX;
         receiver_gap_max = quiet ? 0 : GAP_MAX;
         write_capacity(capacity_plan[phase]);
         if (phase == 0) rsp_hold_request = 1'b1;
         target = stimulus_items + ITEMS_PER_PHASE;
         while (stimulus_items < target) queue_segment();
         while (pending_beats.size() != 0) send_beat(pending_beats.pop_front(), 1'b0, NO_RSP);
         drain_results();
      end

      $display("Run covered %0d input beats over %0d capacity writes and %0d checked results.",
               beats_sent, capacity_writes, results_checked);
      $display("It closed %0d texts, emitted %0d bytes, dropped %0d on a full buffer, %0s%0d.",
               texts_closed, bytes_emitted, dropped_full, "sink held off cycles ",
               held_off_cycles);
      if (mismatch_count == 0) begin
         $display("[ansi_escape_stripper] OK");
      end else begin
         $display("[ansi_escape_stripper] ERROR");
      end
      $finish;
   end

endmodule

// ----- ansi_escape_stripper.f -----
rtl/ansi_pkg.sv
rtl/ansi_if.sv
rtl/ansi_parser.sv
rtl/ansi_escape_stripper.sv
dv/tb_ansi_escape_stripper.sv
